// File: rtl/ptc_pkg.sv
// Shared types, widths and helpers for the pressure and temperature compensation pipeline.
package ptc_pkg;

  // Field widths fixed by the sensor data formats.
  localparam int RawW    = 24;
  localparam int CalW    = 16;
  localparam int OutW    = 32;
  localparam int CfgIdxW = 3;

  // Internal datapath widths, sized from the value ranges of each term.
  localparam int DtW    = RawW + 1;           // temperature difference dT
  localparam int ProdW  = CalW + 1 + DtW;     // calibration word times dT
  localparam int SqDtW  = 2 * DtW;            // dT squared
  localparam int SensW  = 35;                 // first-order sensitivity
  localparam int OffW   = 36;                 // first-order offset
  localparam int TempW  = 19;                 // first-order temperature
  localparam int TiW    = 17;                 // second-order temperature term
  localparam int TdW    = 20;                 // temperature minus a threshold
  localparam int SqW    = 2 * TdW;            // square of such a difference
  localparam int CorrW  = 40;                 // second-order offset and sensitivity terms
  localparam int SdW    = 40;                 // corrected sensitivity
  localparam int OffnW  = 41;                 // corrected offset
  localparam int HalfW  = SdW / 2;            // split point of the wide pressure product
  localparam int PlW    = RawW + HalfW;       // low partial product
  localparam int PhW    = RawW + 1 + HalfW;   // high partial product
  localparam int WideW  = 64;                 // full pressure product
  localparam int QW     = 43;                 // pressure product after the first scaling

  // Scale factors, as shift amounts.
  localparam int C1Shift     = 15;
  localparam int C2Shift     = 16;
  localparam int C5Shift     = 8;
  localparam int SensShift   = 8;
  localparam int OffShift    = 7;
  localparam int TempShift   = 23;
  localparam int TiLoShift   = 33;
  localparam int TiHiShift   = 36;
  localparam int PresShift1  = 21;
  localparam int PresShift2  = 13;

  // Temperature thresholds in hundredths of a degree.
  localparam int TempRef  = 2000;
  localparam int TempVlow = -1500;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESSURE_SENSITIVITY = 3'd0,
    REG_PRESSURE_OFFSET      = 3'd1,
    REG_SENS_TEMP_COEF       = 3'd2,
    REG_OFFSET_TEMP_COEF     = 3'd3,
    REG_REFERENCE_TEMP       = 3'd4,
    REG_TEMP_SENS_COEF       = 3'd5
  } cfg_reg_t;

  // One raw conversion pair.
  typedef struct packed {
    logic [RawW-1:0] pressure_raw;
    logic [RawW-1:0] temp_raw;
  } in_t;

  // One compensated result.
  typedef struct packed {
    logic signed [OutW-1:0] temperature_centi;
    logic signed [OutW-1:0] pressure_tenth_mbar;
  } out_t;

  // Factory calibration words.
  typedef struct packed {
    logic [CalW-1:0] pressure_sensitivity;
    logic [CalW-1:0] pressure_offset;
    logic [CalW-1:0] sens_temp_coef;
    logic [CalW-1:0] offset_temp_coef;
    logic [CalW-1:0] reference_temp;
    logic [CalW-1:0] temp_sens_coef;
  } cal_t;

  // First-order results handed to the second-order section.
  typedef struct packed {
    logic [RawW-1:0]         d1;
    logic signed [SensW-1:0] sens;
    logic signed [OffW-1:0]  off;
    logic signed [TempW-1:0] temp;
    logic [TiW-1:0]          ti_lo;
    logic [TiW-1:0]          ti_hi;
  } front_t;

  // Corrected terms handed to the pressure section.
  typedef struct packed {
    logic [RawW-1:0]         d1;
    logic signed [SdW-1:0]   sd;
    logic signed [OffnW-1:0] offn;
    logic signed [TdW-1:0]   tout;
  } second_t;

  // Signed division by a power of two that truncates toward zero.
  function automatic logic signed [WideW-1:0] trunc_shift(input logic signed [WideW-1:0] x,
                                                          input int unsigned sh);
    logic signed [WideW-1:0] bias;
    bias = x[WideW-1] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (x + bias) >>> sh;
  endfunction

endpackage

// File: rtl/ptc_first.sv
// First-order section: temperature difference, calibration products, offset, sensitivity and temperature.
module ptc_first (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ptc_pkg::in_t    meas,
  input  ptc_pkg::cal_t   cal,
  output logic            out_valid,
  output ptc_pkg::front_t front
);

  // One valid bit per stage.
  logic [2:0] valid;

  // Stage 1 registers.
  logic signed [ptc_pkg::DtW-1:0] dt1;
  logic [ptc_pkg::RawW-1:0]       d1_s1;

  // Stage 2 registers.
  logic signed [ptc_pkg::ProdW-1:0] p3;
  logic signed [ptc_pkg::ProdW-1:0] p4;
  logic signed [ptc_pkg::ProdW-1:0] p6;
  logic signed [ptc_pkg::SqDtW-1:0] pdd;
  logic [ptc_pkg::RawW-1:0]         d1_s2;

  // Operands extended to the product width.
  logic signed [ptc_pkg::ProdW-1:0] dt_ext;
  logic signed [ptc_pkg::ProdW-1:0] c3_ext;
  logic signed [ptc_pkg::ProdW-1:0] c4_ext;
  logic signed [ptc_pkg::ProdW-1:0] c6_ext;
  logic signed [ptc_pkg::SqDtW-1:0] dt_sq_ext;

  // Stage 3 intermediate sums.
  logic signed [ptc_pkg::WideW-1:0] sens_w;
  logic signed [ptc_pkg::WideW-1:0] off_w;
  logic signed [ptc_pkg::WideW-1:0] temp_w;
  logic signed [ptc_pkg::WideW-1:0] tri_w;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[1:0], in_valid};
    end
  end

  assign out_valid = valid[2];

  // Stage 1: difference between the raw temperature and the reference.
  always_ff @(posedge clk) begin
    dt1   <= $signed({1'b0, meas.temp_raw})
           - $signed({1'b0, cal.reference_temp, {ptc_pkg::C5Shift{1'b0}}});
    d1_s1 <= meas.pressure_raw;
  end

  // Stage 2 operands.
  assign dt_ext    = ptc_pkg::ProdW'(dt1);
  assign c3_ext    = $signed({{(ptc_pkg::ProdW - ptc_pkg::CalW){1'b0}}, cal.sens_temp_coef});
  assign c4_ext    = $signed({{(ptc_pkg::ProdW - ptc_pkg::CalW){1'b0}}, cal.offset_temp_coef});
  assign c6_ext    = $signed({{(ptc_pkg::ProdW - ptc_pkg::CalW){1'b0}}, cal.temp_sens_coef});
  assign dt_sq_ext = ptc_pkg::SqDtW'(dt1);

  // Stage 2: the four products of dT.
  always_ff @(posedge clk) begin
    p3    <= c3_ext * dt_ext;
    p4    <= c4_ext * dt_ext;
    p6    <= c6_ext * dt_ext;
    pdd   <= dt_sq_ext * dt_sq_ext;
    d1_s2 <= d1_s1;
  end

  // Stage 3 arithmetic: scale the products and add the base terms.
  always_comb begin
    sens_w = $signed({{(ptc_pkg::WideW - ptc_pkg::CalW - ptc_pkg::C1Shift){1'b0}},
                      cal.pressure_sensitivity, {ptc_pkg::C1Shift{1'b0}}})
           + ptc_pkg::trunc_shift(ptc_pkg::WideW'(p3), ptc_pkg::SensShift);
    off_w  = $signed({{(ptc_pkg::WideW - ptc_pkg::CalW - ptc_pkg::C2Shift){1'b0}},
                      cal.pressure_offset, {ptc_pkg::C2Shift{1'b0}}})
           + ptc_pkg::trunc_shift(ptc_pkg::WideW'(p4), ptc_pkg::OffShift);
    temp_w = ptc_pkg::WideW'(ptc_pkg::TempRef)
           + ptc_pkg::trunc_shift(ptc_pkg::WideW'(p6), ptc_pkg::TempShift);
    // The square is never negative, so plain shifts divide it exactly as truncation does.
    tri_w  = ptc_pkg::WideW'(pdd) + (ptc_pkg::WideW'(pdd) <<< 1);
  end

  // Stage 3: first-order results and both candidate temperature corrections.
  always_ff @(posedge clk) begin
    front.d1    <= d1_s2;
    front.sens  <= ptc_pkg::SensW'(sens_w);
    front.off   <= ptc_pkg::OffW'(off_w);
    front.temp  <= ptc_pkg::TempW'(temp_w);
    front.ti_lo <= ptc_pkg::TiW'(tri_w >>> ptc_pkg::TiLoShift);
    front.ti_hi <= ptc_pkg::TiW'(ptc_pkg::WideW'(pdd) >>> ptc_pkg::TiHiShift);
  end

  // A temperature below the reference can only come from a negative difference.
  a_temp_sign: assert property (@(posedge clk) disable iff (rst)
    valid[2] && (front.temp < ptc_pkg::TempRef) |-> $past(dt1, 2) < 0)
    else $error("temperature below reference without a negative difference");

  // The low-branch correction is never smaller than the high-branch one.
  a_ti_order: assert property (@(posedge clk) disable iff (rst)
    valid[2] |-> front.ti_lo >= front.ti_hi)
    else $error("low-branch temperature correction below high-branch one");

endmodule

// File: rtl/ptc_second.sv
// Second-order section: branch selection, squared terms and corrected offset and sensitivity.
module ptc_second (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ptc_pkg::front_t  front,
  output logic             out_valid,
  output ptc_pkg::second_t second
);

  // One valid bit per stage.
  logic [2:0] valid;

  // Stage 4 registers.
  logic [ptc_pkg::RawW-1:0]         d1_s4;
  logic signed [ptc_pkg::SensW-1:0] sens_s4;
  logic signed [ptc_pkg::OffW-1:0]  off_s4;
  logic signed [ptc_pkg::SqW-1:0]   sqm;
  logic signed [ptc_pkg::SqW-1:0]   sqp;
  logic                             low;
  logic                             vlow;
  logic signed [ptc_pkg::TdW-1:0]   tout_s4;

  // Stage 5 registers.
  logic [ptc_pkg::RawW-1:0]         d1_s5;
  logic signed [ptc_pkg::SensW-1:0] sens_s5;
  logic signed [ptc_pkg::OffW-1:0]  off_s5;
  logic signed [ptc_pkg::CorrW-1:0] offi;
  logic signed [ptc_pkg::CorrW-1:0] sensi;
  logic signed [ptc_pkg::TdW-1:0]   tout_s5;

  // Stage 4 arithmetic.
  logic signed [ptc_pkg::TdW-1:0] temp_ext;
  logic signed [ptc_pkg::TdW-1:0] tm;
  logic signed [ptc_pkg::TdW-1:0] tp;
  logic signed [ptc_pkg::SqW-1:0] tm_ext;
  logic signed [ptc_pkg::SqW-1:0] tp_ext;
  logic [ptc_pkg::TiW-1:0]        ti_sel;

  // Stage 5 arithmetic.
  logic signed [ptc_pkg::WideW-1:0] sqm_w;
  logic signed [ptc_pkg::WideW-1:0] sqp_w;
  logic signed [ptc_pkg::WideW-1:0] offi_w;
  logic signed [ptc_pkg::WideW-1:0] sensi_w;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[1:0], in_valid};
    end
  end

  assign out_valid = valid[2];

  // Stage 4: distances from both thresholds and the compensated temperature.
  always_comb begin
    temp_ext = ptc_pkg::TdW'(front.temp);
    tm       = temp_ext - ptc_pkg::TdW'(ptc_pkg::TempRef);
    tp       = temp_ext - ptc_pkg::TdW'(ptc_pkg::TempVlow);
    tm_ext   = ptc_pkg::SqW'(tm);
    tp_ext   = ptc_pkg::SqW'(tp);
    ti_sel   = (front.temp < ptc_pkg::TempRef) ? front.ti_lo : front.ti_hi;
  end

  always_ff @(posedge clk) begin
    d1_s4   <= front.d1;
    sens_s4 <= front.sens;
    off_s4  <= front.off;
    sqm     <= tm_ext * tm_ext;
    sqp     <= tp_ext * tp_ext;
    low     <= front.temp < ptc_pkg::TempRef;
    vlow    <= front.temp < ptc_pkg::TempVlow;
    tout_s4 <= temp_ext - $signed({{(ptc_pkg::TdW - ptc_pkg::TiW){1'b0}}, ti_sel});
  end

  // Stage 5: second-order offset and sensitivity terms for the selected branch.
  // Both squares are non-negative, so shifts give the truncated quotients.
  always_comb begin
    sqm_w = ptc_pkg::WideW'(sqm);
    sqp_w = ptc_pkg::WideW'(sqp);
    if (low) begin
      offi_w  = (sqm_w + (sqm_w <<< 1)) >>> 1;
      sensi_w = ((sqm_w <<< 2) + sqm_w) >>> 3;
      // Very cold readings add a further correction.
      if (vlow) begin
        offi_w  = offi_w + (sqp_w <<< 3) - sqp_w;
        sensi_w = sensi_w + (sqp_w <<< 2);
      end
    end else begin
      offi_w  = sqm_w >>> 4;
      sensi_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    d1_s5   <= d1_s4;
    sens_s5 <= sens_s4;
    off_s5  <= off_s4;
    offi    <= ptc_pkg::CorrW'(offi_w);
    sensi   <= ptc_pkg::CorrW'(sensi_w);
    tout_s5 <= tout_s4;
  end

  // Stage 6: apply the corrections.
  always_ff @(posedge clk) begin
    second.d1   <= d1_s5;
    second.sd   <= ptc_pkg::SdW'(ptc_pkg::WideW'(sens_s5) - ptc_pkg::WideW'(sensi));
    second.offn <= ptc_pkg::OffnW'(ptc_pkg::WideW'(off_s5) - ptc_pkg::WideW'(offi));
    second.tout <= tout_s5;
  end

  // The sensitivity correction only ever lowers the sensitivity.
  a_sens_drop: assert property (@(posedge clk) disable iff (rst)
    valid[2] |-> second.sd <= $past(front.sens, 3))
    else $error("corrected sensitivity exceeds first-order sensitivity");

endmodule

// File: rtl/ptc_press.sv
// Pressure section: split wide multiply, two truncating scalings and the result register.
module ptc_press (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ptc_pkg::second_t second,
  output logic             out_valid,
  output ptc_pkg::out_t    result
);

  // One valid bit per stage.
  logic [3:0] valid;

  // Stage 7 registers: partial products.
  logic [ptc_pkg::PlW-1:0]          pl;
  logic signed [ptc_pkg::PhW-1:0]   ph;
  logic signed [ptc_pkg::OffnW-1:0] offn_s7;
  logic signed [ptc_pkg::TdW-1:0]   tout_s7;

  // Stage 8 registers: full product.
  logic signed [ptc_pkg::WideW-1:0] prod;
  logic signed [ptc_pkg::OffnW-1:0] offn_s8;
  logic signed [ptc_pkg::TdW-1:0]   tout_s8;

  // Stage 9 registers: first scaling.
  logic signed [ptc_pkg::QW-1:0]    q;
  logic signed [ptc_pkg::OffnW-1:0] offn_s9;
  logic signed [ptc_pkg::TdW-1:0]   tout_s9;

  // Partial product operands.
  logic [ptc_pkg::PlW-1:0]        d1_lo_ext;
  logic [ptc_pkg::PlW-1:0]        sd_lo_ext;
  logic signed [ptc_pkg::PhW-1:0] d1_hi_ext;
  logic signed [ptc_pkg::PhW-1:0] sd_hi_ext;

  // Final subtraction.
  logic signed [ptc_pkg::WideW-1:0] x_w;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], in_valid};
    end
  end

  assign out_valid = valid[3];

  // Stage 7: raw pressure times the low and high halves of the sensitivity.
  assign d1_lo_ext = {{(ptc_pkg::PlW - ptc_pkg::RawW){1'b0}}, second.d1};
  assign sd_lo_ext = {{(ptc_pkg::PlW - ptc_pkg::HalfW){1'b0}}, second.sd[ptc_pkg::HalfW-1:0]};
  assign d1_hi_ext = $signed({{(ptc_pkg::PhW - ptc_pkg::RawW){1'b0}}, second.d1});
  assign sd_hi_ext = ptc_pkg::PhW'($signed(second.sd[ptc_pkg::SdW-1:ptc_pkg::HalfW]));

  always_ff @(posedge clk) begin
    pl      <= d1_lo_ext * sd_lo_ext;
    ph      <= d1_hi_ext * sd_hi_ext;
    offn_s7 <= second.offn;
    tout_s7 <= second.tout;
  end

  // Stage 8: recombine the partial products.
  always_ff @(posedge clk) begin
    prod    <= (ptc_pkg::WideW'(ph) <<< ptc_pkg::HalfW) + $signed(ptc_pkg::WideW'(pl));
    offn_s8 <= offn_s7;
    tout_s8 <= tout_s7;
  end

  // Stage 9: first scaling of the product.
  always_ff @(posedge clk) begin
    q       <= ptc_pkg::QW'(ptc_pkg::trunc_shift(prod, ptc_pkg::PresShift1));
    offn_s9 <= offn_s8;
    tout_s9 <= tout_s8;
  end

  // Stage 10: subtract the offset, scale, and present the result.
  assign x_w = ptc_pkg::WideW'(q) - ptc_pkg::WideW'(offn_s9);

  always_ff @(posedge clk) begin
    result.pressure_tenth_mbar <= ptc_pkg::OutW'(ptc_pkg::trunc_shift(x_w, ptc_pkg::PresShift2));
    result.temperature_centi   <= ptc_pkg::OutW'(tout_s9);
  end

  // The temperature rides through this section unchanged.
  a_temp_carry: assert property (@(posedge clk) disable iff (rst)
    valid[3] |-> result.temperature_centi == $past(second.tout, 4))
    else $error("temperature altered in pressure section");

endmodule

// File: rtl/pressure_temp_compensation_core.sv
// Top level: calibration registers, request handshake and the compensation pipeline.
// An accepted request passes through the ten register stages and gives its result with
// done high. Throughput: one request per cycle while busy is low; the wide pressure
// multiply is split over two stages. Reset clears the calibration words to zero and
// empties the pipeline; busy is registered and drops at a clock edge that samples reset low.
// Results cannot be held off by the receiver.
module pressure_temp_compensation_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  ptc_pkg::in_t                 meas,
  output logic                         done,
  output ptc_pkg::out_t                result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ptc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ptc_pkg::CalW-1:0]     cfg_data
);

  ptc_pkg::cal_t    cal;
  ptc_pkg::front_t  front;
  ptc_pkg::second_t second;
  logic             front_valid;
  logic             second_valid;
  logic             accept;

  // Busy only covers the reset period; the pipeline takes a request every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Calibration register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ptc_pkg::cfg_reg_t'(cfg_index))
        ptc_pkg::REG_PRESSURE_SENSITIVITY: begin
          cal.pressure_sensitivity <= cfg_data;
        end
        ptc_pkg::REG_PRESSURE_OFFSET: begin
          cal.pressure_offset <= cfg_data;
        end
        ptc_pkg::REG_SENS_TEMP_COEF: begin
          cal.sens_temp_coef <= cfg_data;
        end
        ptc_pkg::REG_OFFSET_TEMP_COEF: begin
          cal.offset_temp_coef <= cfg_data;
        end
        ptc_pkg::REG_REFERENCE_TEMP: begin
          cal.reference_temp <= cfg_data;
        end
        ptc_pkg::REG_TEMP_SENS_COEF: begin
          cal.temp_sens_coef <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // First-order section.
  ptc_first u_first (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .meas      (meas),
    .cal       (cal),
    .out_valid (front_valid),
    .front     (front)
  );

  // Second-order section.
  ptc_second u_second (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .front     (front),
    .out_valid (second_valid),
    .second    (second)
  );

  // Pressure section and result register.
  ptc_press u_press (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (second_valid),
    .second    (second),
    .out_valid (done),
    .result    (result)
  );

  // Every result traces back to an accepted request that entered the pipeline.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 10))
    else $error("result strobe without a matching request");

endmodule
